>>> rtl/sha256_pkg.sv
`timescale 1ns / 1ps

package sha256_pkg;

    // widths of the stream payloads
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 32;
    localparam int IDX_W      = 3;
    localparam int OUT_DATA_W = 40;
    localparam int ROUND_W    = 6;
    localparam int WIN_DEPTH  = 16;
    localparam int PEND_W     = 6;
    localparam int BLK_W      = 55;
    localparam int LEN_W      = 64;

    // padding codes and bounds
    localparam logic [BYTE_W-1:0] PAD_MARK     = 8'h80;
    localparam logic [BYTE_W-1:0] PAD_ZERO     = 8'h00;
    localparam logic [PEND_W-1:0] PEND_LAST    = 6'd63;
    localparam logic [PEND_W-1:0] PEND_PRE_LEN = 6'd55;
    localparam logic [ROUND_W-1:0] ROUND_LAST  = 6'd63;
    localparam logic [IDX_W-1:0]  IDX_LAST     = 3'd7;

    // initial chaining value
    localparam logic [WORD_W-1:0] IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // control from the sequencer to the compression core
    typedef struct packed {
        logic              byte_en;
        logic              word_en;
        logic              start;
        logic              reinit;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  rd_idx;
    } core_ctrl_t;

    function automatic logic [WORD_W-1:0] ror(input logic [WORD_W-1:0] x,
                                              input int unsigned n);
        ror = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] x);
        big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
    endfunction

    function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] x);
        big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma0(input logic [WORD_W-1:0] x);
        small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [WORD_W-1:0] small_sigma1(input logic [WORD_W-1:0] x);
        small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

    // round constants
    function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] t);
        case (t)
            6'd0:  round_k = 32'h428a2f98;
            6'd1:  round_k = 32'h71374491;
            6'd2:  round_k = 32'hb5c0fbcf;
            6'd3:  round_k = 32'he9b5dba5;
            6'd4:  round_k = 32'h3956c25b;
            6'd5:  round_k = 32'h59f111f1;
            6'd6:  round_k = 32'h923f82a4;
            6'd7:  round_k = 32'hab1c5ed5;
            6'd8:  round_k = 32'hd807aa98;
            6'd9:  round_k = 32'h12835b01;
            6'd10: round_k = 32'h243185be;
            6'd11: round_k = 32'h550c7dc3;
            6'd12: round_k = 32'h72be5d74;
            6'd13: round_k = 32'h80deb1fe;
            6'd14: round_k = 32'h9bdc06a7;
            6'd15: round_k = 32'hc19bf174;
            6'd16: round_k = 32'he49b69c1;
            6'd17: round_k = 32'hefbe4786;
            6'd18: round_k = 32'h0fc19dc6;
            6'd19: round_k = 32'h240ca1cc;
            6'd20: round_k = 32'h2de92c6f;
            6'd21: round_k = 32'h4a7484aa;
            6'd22: round_k = 32'h5cb0a9dc;
            6'd23: round_k = 32'h76f988da;
            6'd24: round_k = 32'h983e5152;
            6'd25: round_k = 32'ha831c66d;
            6'd26: round_k = 32'hb00327c8;
            6'd27: round_k = 32'hbf597fc7;
            6'd28: round_k = 32'hc6e00bf3;
            6'd29: round_k = 32'hd5a79147;
            6'd30: round_k = 32'h06ca6351;
            6'd31: round_k = 32'h14292967;
            6'd32: round_k = 32'h27b70a85;
            6'd33: round_k = 32'h2e1b2138;
            6'd34: round_k = 32'h4d2c6dfc;
            6'd35: round_k = 32'h53380d13;
            6'd36: round_k = 32'h650a7354;
            6'd37: round_k = 32'h766a0abb;
            6'd38: round_k = 32'h81c2c92e;
            6'd39: round_k = 32'h92722c85;
            6'd40: round_k = 32'ha2bfe8a1;
            6'd41: round_k = 32'ha81a664b;
            6'd42: round_k = 32'hc24b8b70;
            6'd43: round_k = 32'hc76c51a3;
            6'd44: round_k = 32'hd192e819;
            6'd45: round_k = 32'hd6990624;
            6'd46: round_k = 32'hf40e3585;
            6'd47: round_k = 32'h106aa070;
            6'd48: round_k = 32'h19a4c116;
            6'd49: round_k = 32'h1e376c08;
            6'd50: round_k = 32'h2748774c;
            6'd51: round_k = 32'h34b0bcb5;
            6'd52: round_k = 32'h391c0cb3;
            6'd53: round_k = 32'h4ed8aa4a;
            6'd54: round_k = 32'h5b9cca4f;
            6'd55: round_k = 32'h682e6ff3;
            6'd56: round_k = 32'h748f82ee;
            6'd57: round_k = 32'h78a5636f;
            6'd58: round_k = 32'h84c87814;
            6'd59: round_k = 32'h8cc70208;
            6'd60: round_k = 32'h90befffa;
            6'd61: round_k = 32'ha4506ceb;
            6'd62: round_k = 32'hbef9a3f7;
            6'd63: round_k = 32'hc67178f2;
            default: round_k = 32'h0;
        endcase
    endfunction

endpackage

>>> rtl/sha256_core.sv
`timescale 1ns / 1ps

module sha256_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sha256_pkg::core_ctrl_t         ctrl,
    output logic                           done,
    output logic [sha256_pkg::WORD_W-1:0]  rd_word
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ADD
    } core_state_t;

    core_state_t                          state_reg, state_next;
    logic [sha256_pkg::ROUND_W-1:0]       rnd_reg, rnd_next;
    logic [sha256_pkg::WORD_W-1:0]        chain_reg [8];
    logic [sha256_pkg::WORD_W-1:0]        chain_next [8];
    logic [sha256_pkg::WORD_W-1:0]        v_reg [8];
    logic [sha256_pkg::WORD_W-1:0]        v_next [8];
    logic [sha256_pkg::WORD_W-1:0]        win_reg [sha256_pkg::WIN_DEPTH];
    logic [sha256_pkg::WORD_W-1:0]        win_next [sha256_pkg::WIN_DEPTH];
    logic [23:0]                          acc_reg, acc_next;
    logic [sha256_pkg::WORD_W-1:0]        t1, t2, w_new, word_in;

    assign done    = (state_reg == C_ADD);
    assign rd_word = chain_reg[ctrl.rd_idx];
    assign word_in = {acc_reg, ctrl.data};

    // one round of the compression and one step of the message schedule
    always_comb begin
        t1 = v_reg[7] + sha256_pkg::big_sigma1(v_reg[4])
           + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
           + sha256_pkg::round_k(rnd_reg) + win_reg[0];
        t2 = sha256_pkg::big_sigma0(v_reg[0])
           + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        w_new = sha256_pkg::small_sigma1(win_reg[14]) + win_reg[9]
              + sha256_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    end

    // sequencer for rounds, byte loading and chaining update
    always_comb begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        chain_next = chain_reg;
        v_next     = v_reg;
        win_next   = win_reg;
        acc_next   = acc_reg;

        // byte loading into the schedule window
        if (ctrl.byte_en) begin
            acc_next = word_in[23:0];
            if (ctrl.word_en) begin
                for (int i = 0; i < sha256_pkg::WIN_DEPTH - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[sha256_pkg::WIN_DEPTH-1] = word_in;
            end
        end

        case (state_reg)
            C_IDLE: begin
                if (ctrl.start) begin
                    v_next     = chain_reg;
                    rnd_next   = '0;
                    state_next = C_RUN;
                end
            end
            C_RUN: begin
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                for (int i = 0; i < sha256_pkg::WIN_DEPTH - 1; i++) begin
                    win_next[i] = win_reg[i+1];
                end
                win_next[sha256_pkg::WIN_DEPTH-1] = w_new;
                rnd_next = rnd_reg + 1'b1;
                if (rnd_reg == sha256_pkg::ROUND_LAST) begin
                    state_next = C_ADD;
                end
            end
            C_ADD: begin
                for (int i = 0; i < 8; i++) begin
                    chain_next[i] = chain_reg[i] + v_reg[i];
                end
                state_next = C_IDLE;
            end
            default: begin
                state_next = C_IDLE;
            end
        endcase

        // back to the initial value for the next message
        if (ctrl.reinit) begin
            chain_next = sha256_pkg::IV;
        end
    end

    // state and chaining value
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= C_IDLE;
            rnd_reg   <= '0;
            chain_reg <= sha256_pkg::IV;
        end else begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            chain_reg <= chain_next;
        end
    end

    // working variables and schedule window
    always_ff @(posedge aclk) begin
        v_reg   <= v_next;
        win_reg <= win_next;
        acc_reg <= acc_next;
    end

endmodule

>>> rtl/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps

// SHA-256 hasher fed one message byte per input word.
// Input channel s_*: s_tuser = 0 carries a message byte in s_tdata, s_tuser = 1
// finishes the message (s_tdata ignored). Output channel m_*: eight digest words,
// H0 first, m_tlast on the eighth.
// Input bytes are taken one per cycle while s_tready is high; the 64th byte of a
// block starts the compression, 64 rounds on one shared round unit followed by
// the chaining add, and s_tready stays low until the chaining add is done.
// Finish: padding bytes are fed through the same byte path, one per cycle, then
// one or two compressions run before the first digest word shows up.
// Digest words leave through an output register at one word per cycle while
// m_tready is high; a stall holds the word, and no input is taken until the
// eighth word is taken, after which the hasher is ready for a new message.
// Reset (aresetn low, synchronous) loads the initial hash value, clears the
// byte and block counts and drops m_tvalid.

module sha256_stream_hasher_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sha256_pkg::BYTE_W-1:0]       s_tdata,   // [7:0] data_byte
    input  logic                                s_tuser,   // [0] req_type
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sha256_pkg::OUT_DATA_W-1:0]   m_tdata,   // [31:0] digest_word,
                                                           // [34:32] word_index, zeros above
    output logic                                m_tlast    // last_word
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN,
        ST_COMP,
        ST_OUT
    } state_t;

    state_t                                 state_reg, state_next;
    logic [sha256_pkg::PEND_W-1:0]          pend_reg, pend_next;
    logic [sha256_pkg::BLK_W-1:0]           blk_reg, blk_next;
    logic [sha256_pkg::LEN_W-1:0]           len_reg, len_next;
    logic                                   fin_reg, fin_next;
    logic                                   lenph_reg, lenph_next;
    logic [sha256_pkg::IDX_W-1:0]           idx_reg, idx_next;
    logic                                   m_tvalid_reg, m_tvalid_next;
    logic [sha256_pkg::OUT_DATA_W-1:0]      m_tdata_reg, m_tdata_next;
    logic                                   m_tlast_reg, m_tlast_next;
    logic                                   push_en;
    logic [sha256_pkg::BYTE_W-1:0]          push_data;
    sha256_pkg::core_ctrl_t                 ctrl;
    logic                                   core_done;
    logic [sha256_pkg::WORD_W-1:0]          core_word;

    sha256_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .done    (core_done),
        .rd_word (core_word)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // sequencer: byte loading, padding, compression wait, digest output
    always_comb begin
        state_next    = state_reg;
        pend_next     = pend_reg;
        blk_next      = blk_reg;
        len_next      = len_reg;
        fin_next      = fin_reg;
        lenph_next    = lenph_reg;
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;
        push_en       = 1'b0;
        push_data     = sha256_pkg::PAD_ZERO;
        ctrl          = '0;
        ctrl.rd_idx   = idx_reg;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    push_en = 1'b1;
                    if (!s_tuser) begin
                        push_data = s_tdata;
                    end else begin
                        push_data = sha256_pkg::PAD_MARK;
                        fin_next  = 1'b1;
                        len_next  = {blk_reg, pend_reg, 3'b000};
                    end
                end
            end
            ST_PAD: begin
                push_en = 1'b1;
            end
            ST_LEN: begin
                push_en   = 1'b1;
                push_data = len_reg[sha256_pkg::LEN_W-1 -: sha256_pkg::BYTE_W];
                len_next  = {len_reg[sha256_pkg::LEN_W-sha256_pkg::BYTE_W-1:0],
                             sha256_pkg::PAD_ZERO};
            end
            ST_COMP: begin
                if (core_done) begin
                    if (!fin_reg) begin
                        state_next = ST_IDLE;
                    end else if (lenph_reg) begin
                        state_next = ST_OUT;
                        idx_next   = '0;
                    end else begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_OUT: begin
                if (!m_tvalid_reg) begin
                    // first digest word
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b00000, idx_reg, core_word};
                    m_tlast_next  = (idx_reg == sha256_pkg::IDX_LAST);
                end else if (m_tready) begin
                    if (m_tlast_reg) begin
                        m_tvalid_next = 1'b0;
                        m_tlast_next  = 1'b0;
                        ctrl.reinit   = 1'b1;
                        pend_next     = '0;
                        blk_next      = '0;
                        fin_next      = 1'b0;
                        lenph_next    = 1'b0;
                        state_next    = ST_IDLE;
                    end else begin
                        idx_next     = idx_reg + 1'b1;
                        ctrl.rd_idx  = idx_next;
                        m_tdata_next = {5'b00000, idx_next, core_word};
                        m_tlast_next = (idx_next == sha256_pkg::IDX_LAST);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // common byte path into the core
        if (push_en) begin
            ctrl.byte_en = 1'b1;
            ctrl.word_en = (pend_reg[1:0] == 2'b11);
            ctrl.data    = push_data;
            pend_next    = pend_reg + 1'b1;
            if (pend_reg == sha256_pkg::PEND_LAST) begin
                ctrl.start = 1'b1;
                blk_next   = blk_reg + 1'b1;
                state_next = ST_COMP;
            end else if (fin_next && pend_reg == sha256_pkg::PEND_PRE_LEN) begin
                lenph_next = 1'b1;
                state_next = ST_LEN;
            end else if (fin_next) begin
                state_next = (lenph_reg) ? ST_LEN : ST_PAD;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            pend_reg     <= '0;
            blk_reg      <= '0;
            fin_reg      <= 1'b0;
            lenph_reg    <= 1'b0;
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            blk_reg      <= blk_next;
            fin_reg      <= fin_next;
            lenph_reg    <= lenph_next;
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        len_reg     <= len_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

>>> rtl/sha256_checker.sv
`timescale 1ns / 1ps

module sha256_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [sha256_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic                               m_tlast
);

    // a stalled digest word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("digest word changed while stalled");

    // no input is taken while a digest is being delivered
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready during digest output");

    // a finish word is followed by a busy period
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser |=> !s_tready)
        else $error("ready right after a finish word");

    // last flag exactly on word index seven
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == sha256_pkg::IDX_LAST)))
        else $error("last flag does not match word index");

    // next word index follows the accepted one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("digest word index out of order");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_sha256_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
